// ===== hdl/look_at_view_matrix_defines.svh =====
// ----------------------------------------------------------------------------
// Look-at view matrix: assertion macros
// Concurrent checks for simulation; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define LAVM_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lavm: check failed");
// antecedent implies consequent in the next cycle
`define LAVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lavm: check failed");
`else
`define LAVM_ASSERT(label, clk, rst, ante, cons)
`define LAVM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/lavm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_pkg
// Types, constants and index tables shared by the look-at view matrix block.
// ----------------------------------------------------------------------------
package lavm_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int DIFF_W        = 33;
   localparam int WIDE_W        = 64;
   localparam int ROOT_STEPS    = 32;
   localparam int QUEUE_DEPTH   = 2;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] eye;
      logic [2:0][DIFF_W-1:0]  diff;
      logic [2:0][COORD_W-1:0] up;
   } item_type;

   typedef struct packed {
      logic done;
      logic degen;
   } norm_stat_type;

   typedef struct packed {
      logic       valid;
      logic       first;
      logic       neg;
      logic       last;
      logic [1:0] dst;
   } mac_tag_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_ALIGN,
      N_SQUARE,
      N_ROOT,
      N_DIVIDE,
      N_DONE
   } norm_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_NORM_Z,
      B_CROSS_C,
      B_NORM_X,
      B_CROSS_Y,
      B_DOT,
      B_EMIT
   } back_state_type;

   // cross product a x b: products (a1 b2, a2 b1, a2 b0, a0 b2, a0 b1, a1 b0)
   function automatic logic [1:0] cross_a(input logic [3:0] k);
      logic [1:0] r;
      case (k)
         4'd0:    r = 2'd1;
         4'd1:    r = 2'd2;
         4'd2:    r = 2'd2;
         4'd3:    r = 2'd0;
         4'd4:    r = 2'd0;
         4'd5:    r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] cross_b(input logic [3:0] k);
      logic [1:0] r;
      case (k)
         4'd0:    r = 2'd2;
         4'd1:    r = 2'd1;
         4'd2:    r = 2'd0;
         4'd3:    r = 2'd2;
         4'd4:    r = 2'd1;
         4'd5:    r = 2'd0;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   // dot products: k walks row (axis) major, column (coordinate) minor
   function automatic logic [1:0] dot_row(input logic [3:0] k);
      logic [1:0] r;
      case (k)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         4'd6, 4'd7, 4'd8: r = 2'd2;
         default:          r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] dot_col(input logic [3:0] k);
      logic [1:0] r;
      case (k)
         4'd0, 4'd3, 4'd6: r = 2'd0;
         4'd1, 4'd4, 4'd7: r = 2'd1;
         4'd2, 4'd5, 4'd8: r = 2'd2;
         default:          r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Builds the 4x4 look-at view matrix from eye, target and up, Q16.16.
// ----------------------------------------------------------------------------
// Each item goes through the normalizer twice, for the forward and then the
//   side axis; its four rows then follow back to back, one strobe each. The
//   back end works on one item per pass and pops the next from the queue only
//   after its last row; the iterative square root and divider in the
//   normalizer set the length of each pass.
// A two-entry queue accepts new items while the back end works; busy is high
//   only when the queue is full. Synchronous reset empties the queue and idles
//   the sequencer; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
   parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_up_x,
   input  logic signed [31:0] req_up_y,
   input  logic signed [31:0] req_up_z,
   output logic               rsp_valid,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_elem_a,
   output logic signed [31:0] rsp_elem_b,
   output logic signed [31:0] rsp_elem_c,
   output logic signed [31:0] rsp_elem_d,
   output logic               rsp_degenerate,
   output logic               rsp_saturated,
   output logic               rsp_last_row
);

   // queue handoff between front and back
   logic                        item_valid;
   lavm_pkg::item_type          item;
   logic                        item_pop;

   // normalizer control, shared for both the forward and the side axis
   logic                        norm_start;
   logic signed [63:0]          norm_vec [3];
   lavm_pkg::norm_stat_type     norm_stat;
   logic signed [FRAC_BITS+2:0] norm_unit [3];

   // front: take each transfer, form eye minus target, queue it
   lavm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_eye_x    (req_eye_x),
      .req_eye_y    (req_eye_y),
      .req_eye_z    (req_eye_z),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .req_target_z (req_target_z),
      .req_up_x     (req_up_x),
      .req_up_y     (req_up_y),
      .req_up_z     (req_up_z),
      .item_valid   (item_valid),
      .item         (item),
      .item_pop     (item_pop)
   );

   // normalizer: align, square, root, divide one component at a time
   lavm_norm #(
      .FRAC_BITS (FRAC_BITS)
   ) u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec   (norm_vec),
      .stat  (norm_stat),
      .unit  (norm_unit)
   );

   // back: sequence the axes, products and the four row strobes
   lavm_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .norm_start     (norm_start),
      .norm_vec       (norm_vec),
      .norm_stat      (norm_stat),
      .norm_unit      (norm_unit),
      .rsp_valid      (rsp_valid),
      .rsp_row_index  (rsp_row_index),
      .rsp_elem_a     (rsp_elem_a),
      .rsp_elem_b     (rsp_elem_b),
      .rsp_elem_c     (rsp_elem_c),
      .rsp_elem_d     (rsp_elem_d),
      .rsp_degenerate (rsp_degenerate),
      .rsp_saturated  (rsp_saturated),
      .rsp_last_row   (rsp_last_row)
   );

endmodule

// ===== hdl/lavm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_front
// Accepts request transfers, forms eye minus target, and queues the items.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"
module lavm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [31:0]       req_eye_x,
   input  logic signed [31:0]       req_eye_y,
   input  logic signed [31:0]       req_eye_z,
   input  logic signed [31:0]       req_target_x,
   input  logic signed [31:0]       req_target_y,
   input  logic signed [31:0]       req_target_z,
   input  logic signed [31:0]       req_up_x,
   input  logic signed [31:0]       req_up_y,
   input  logic signed [31:0]       req_up_z,
   output logic                     item_valid,
   output lavm_pkg::item_type       item,
   input  logic                     item_pop
);

   localparam int PTR_W = $clog2(lavm_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(lavm_pkg::QUEUE_DEPTH + 1);

   lavm_pkg::item_type entry_ff [lavm_pkg::QUEUE_DEPTH];
   lavm_pkg::item_type entry_in;
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;

   assign busy       = (count_ff == CNT_W'(lavm_pkg::QUEUE_DEPTH));
   assign push       = start && !busy;
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in.eye  = {req_eye_z, req_eye_y, req_eye_x};
      entry_in.up   = {req_up_z, req_up_y, req_up_x};
      entry_in.diff[0] = 33'(req_eye_x) - 33'(req_target_x);
      entry_in.diff[1] = 33'(req_eye_y) - 33'(req_target_y);
      entry_in.diff[2] = 33'(req_eye_z) - 33'(req_target_z);
      count_in = count_ff + CNT_W'(push) - CNT_W'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (item_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   `LAVM_ASSERT(front_pop_nonempty, clock, reset, item_pop, count_ff != '0)

endmodule

// ===== hdl/lavm_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_norm
// Iterative vector normalizer: align, sum of squares, square root, divide.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"
module lavm_norm #(
   parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [63:0]            vec [3],
   output lavm_pkg::norm_stat_type       stat,
   output logic signed [FRAC_BITS+2:0]   unit [3]
);

   localparam int COMP_W = FRAC_BITS + 3;
   localparam int NUM_W  = 32 + FRAC_BITS;
   localparam int CNT_W  = $clog2(FRAC_BITS + 2);

   lavm_pkg::norm_state_type state_ff, state_in;

   logic [63:0]          vm_ff [3];
   logic                 vs_ff [3];
   logic [1:0]           idx_ff;
   logic [61:0]          sq_prod_ff;
   logic [63:0]          sq_acc_ff;
   logic [63:0]          root_s_ff, root_r_ff, root_bit_ff;
   logic [4:0]           root_cnt_ff;
   logic [CNT_W-1:0]     step_ff;
   logic [31:0]          rem_ff;
   logic [FRAC_BITS:0]   nb_ff, q_ff;
   logic signed [COMP_W-1:0] unit_ff [3];
   logic                 degen_ff;

   logic [63:0]          or_v;
   logic                 big8, big1, small8, small1, is_zero;
   logic [30:0]          sel_mag;
   logic                 sel_sign;
   logic [63:0]          root_try;
   logic [NUM_W-1:0]     num;
   logic [32:0]          trial;
   logic                 ge;
   logic [FRAC_BITS:0]   q_next;
   logic                 last_step;

   always_comb begin
      or_v    = vm_ff[0] | vm_ff[1] | vm_ff[2];
      big8    = |or_v[63:39];
      big1    = |or_v[63:31];
      small8  = ~|or_v[63:22];
      small1  = ~|or_v[63:30];
      is_zero = (or_v == '0);
      case (idx_ff)
         2'd0:    begin sel_mag = vm_ff[0][30:0]; sel_sign = vs_ff[0]; end
         2'd1:    begin sel_mag = vm_ff[1][30:0]; sel_sign = vs_ff[1]; end
         2'd2:    begin sel_mag = vm_ff[2][30:0]; sel_sign = vs_ff[2]; end
         default: begin sel_mag = '0; sel_sign = 1'b0; end
      endcase
      root_try  = root_r_ff + root_bit_ff;
      num       = {1'b0, sel_mag, FRAC_BITS'(0)} + NUM_W'(root_r_ff[31:1]);
      trial     = {rem_ff, nb_ff[FRAC_BITS]};
      ge        = (trial >= {1'b0, root_r_ff[31:0]});
      q_next    = {q_ff[FRAC_BITS-1:0], ge};
      last_step = (step_ff == CNT_W'(FRAC_BITS + 1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lavm_pkg::N_IDLE:   if (start) state_in = lavm_pkg::N_ALIGN;
         lavm_pkg::N_ALIGN: begin
            if (is_zero) state_in = lavm_pkg::N_DONE;
            else if (!big1 && !small1) state_in = lavm_pkg::N_SQUARE;
         end
         lavm_pkg::N_SQUARE: if (idx_ff == 2'd3) state_in = lavm_pkg::N_ROOT;
         lavm_pkg::N_ROOT: begin
            if (root_cnt_ff == 5'(lavm_pkg::ROOT_STEPS - 1)) state_in = lavm_pkg::N_DIVIDE;
         end
         lavm_pkg::N_DIVIDE: begin
            if (last_step && idx_ff == 2'd2) state_in = lavm_pkg::N_DONE;
         end
         lavm_pkg::N_DONE:   state_in = lavm_pkg::N_IDLE;
         default:            state_in = lavm_pkg::N_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      stat.done  = (state_ff == lavm_pkg::N_DONE);
      stat.degen = degen_ff;
   end

   assign unit = unit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lavm_pkg::N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         lavm_pkg::N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  vs_ff[i] <= vec[i][63];
                  vm_ff[i] <= vec[i][63] ? 64'(-vec[i]) : 64'(vec[i]);
               end
               degen_ff <= 1'b0;
            end
         end
         lavm_pkg::N_ALIGN: begin
            // move the leading one of the largest magnitude to bit 30
            for (int i = 0; i < 3; i++) begin
               if (big8) vm_ff[i] <= vm_ff[i] >> 8;
               else if (big1) vm_ff[i] <= vm_ff[i] >> 1;
               else if (small8) vm_ff[i] <= vm_ff[i] << 8;
               else if (small1) vm_ff[i] <= vm_ff[i] << 1;
            end
            if (is_zero) begin
               degen_ff <= 1'b1;
               for (int i = 0; i < 3; i++) unit_ff[i] <= '0;
            end
            idx_ff    <= 2'd0;
            sq_acc_ff <= '0;
         end
         lavm_pkg::N_SQUARE: begin
            sq_prod_ff <= sel_mag * sel_mag;
            if (idx_ff != 2'd0) sq_acc_ff <= sq_acc_ff + 64'(sq_prod_ff);
            idx_ff <= idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               root_s_ff   <= sq_acc_ff + 64'(sq_prod_ff);
               root_r_ff   <= '0;
               root_bit_ff <= 64'd1 << 62;
               root_cnt_ff <= '0;
            end
         end
         lavm_pkg::N_ROOT: begin
            if (root_s_ff >= root_try) begin
               root_s_ff <= root_s_ff - root_try;
               root_r_ff <= (root_r_ff >> 1) + root_bit_ff;
            end else begin
               root_r_ff <= root_r_ff >> 1;
            end
            root_bit_ff <= root_bit_ff >> 2;
            root_cnt_ff <= root_cnt_ff + 5'd1;
            idx_ff      <= 2'd0;
            step_ff     <= '0;
         end
         lavm_pkg::N_DIVIDE: begin
            if (step_ff == '0) begin
               rem_ff  <= 32'(num[NUM_W-1:FRAC_BITS+1]);
               nb_ff   <= num[FRAC_BITS:0];
               q_ff    <= '0;
               step_ff <= step_ff + CNT_W'(1);
            end else begin
               rem_ff <= ge ? 32'(trial - {1'b0, root_r_ff[31:0]}) : trial[31:0];
               q_ff   <= q_next;
               nb_ff  <= nb_ff << 1;
               if (last_step) begin
                  unit_ff[idx_ff] <= sel_sign ? -COMP_W'(q_next) : COMP_W'(q_next);
                  idx_ff  <= idx_ff + 2'd1;
                  step_ff <= '0;
               end else begin
                  step_ff <= step_ff + CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   `LAVM_ASSERT_NEXT(norm_done_pulse, clock, reset, stat.done, !stat.done)

endmodule

// ===== hdl/lavm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_back
// Sequencer: axes, cross and dot products on a shared MAC, row output.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"
module lavm_back #(
   parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  lavm_pkg::item_type            item,
   output logic                          item_pop,
   output logic                          norm_start,
   output logic signed [63:0]            norm_vec [3],
   input  lavm_pkg::norm_stat_type       norm_stat,
   input  logic signed [FRAC_BITS+2:0]   norm_unit [3],
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_row_index,
   output logic signed [31:0]            rsp_elem_a,
   output logic signed [31:0]            rsp_elem_b,
   output logic signed [31:0]            rsp_elem_c,
   output logic signed [31:0]            rsp_elem_d,
   output logic                          rsp_degenerate,
   output logic                          rsp_saturated,
   output logic                          rsp_last_row
);

   localparam int COMP_W = FRAC_BITS + 3;
   localparam int PROD_W = 32 + COMP_W;

   lavm_pkg::back_state_type state_ff, state_in;

   logic signed [31:0]       eye_ff [3];
   logic signed [31:0]       up_ff [3];
   logic signed [COMP_W-1:0] z_ff [3], x_ff [3], y_ff [3];
   logic signed [63:0]       c_ff [3];
   logic signed [31:0]       dot_ff [3];
   logic                     sat_ff, degen_ff;
   logic [3:0]               k_ff;
   logic [1:0]               row_ff;
   lavm_pkg::mac_tag_type    tag_ff, tag_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [63:0]       acc_ff;

   logic signed [31:0]       mul_a;
   logic signed [COMP_W-1:0] mul_b;
   logic signed [63:0]       prod_ext, sum, rnd;
   logic                     phase_end;
   logic [1:0]               col;

   logic                     rsp_valid_ff, rsp_last_ff, rsp_sat_ff, rsp_degen_ff;
   logic [1:0]               rsp_row_ff;
   logic signed [31:0]       rsp_a_ff, rsp_b_ff, rsp_c_ff, rsp_d_ff;

   // operand selection and tags for the shared multiplier
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      tag_in = '0;
      col    = lavm_pkg::dot_col(k_ff);
      case (state_ff)
         lavm_pkg::B_CROSS_C, lavm_pkg::B_CROSS_Y: begin
            if (state_ff == lavm_pkg::B_CROSS_C) begin
               mul_a = up_ff[lavm_pkg::cross_a(k_ff)];
            end else begin
               mul_a = 32'(z_ff[lavm_pkg::cross_a(k_ff)]);
            end
            mul_b        = (state_ff == lavm_pkg::B_CROSS_C) ?
                           z_ff[lavm_pkg::cross_b(k_ff)] : x_ff[lavm_pkg::cross_b(k_ff)];
            tag_in.valid = (k_ff < 4'd6);
            tag_in.first = !k_ff[0];
            tag_in.neg   = k_ff[0];
            tag_in.last  = k_ff[0];
            tag_in.dst   = k_ff[2:1];
         end
         lavm_pkg::B_DOT: begin
            mul_a = eye_ff[col];
            case (lavm_pkg::dot_row(k_ff))
               2'd0:    mul_b = x_ff[col];
               2'd1:    mul_b = y_ff[col];
               default: mul_b = z_ff[col];
            endcase
            tag_in.valid = (k_ff < 4'd9);
            tag_in.first = (col == 2'd0);
            tag_in.neg   = 1'b1;
            tag_in.last  = (col == 2'd2);
            tag_in.dst   = lavm_pkg::dot_row(k_ff);
         end
         default: begin
         end
      endcase
      prod_ext = 64'(prod_ff);
      sum      = (tag_ff.first ? 64'sd0 : acc_ff) + (tag_ff.neg ? -prod_ext : prod_ext);
      rnd      = (sum + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      case (state_ff)
         lavm_pkg::B_CROSS_C, lavm_pkg::B_CROSS_Y: phase_end = (k_ff == 4'd7);
         lavm_pkg::B_DOT:                          phase_end = (k_ff == 4'd10);
         default:                                  phase_end = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lavm_pkg::B_IDLE:    if (item_valid) state_in = lavm_pkg::B_NORM_Z;
         lavm_pkg::B_NORM_Z:  if (norm_stat.done) state_in = lavm_pkg::B_CROSS_C;
         lavm_pkg::B_CROSS_C: if (phase_end) state_in = lavm_pkg::B_NORM_X;
         lavm_pkg::B_NORM_X:  if (norm_stat.done) state_in = lavm_pkg::B_CROSS_Y;
         lavm_pkg::B_CROSS_Y: if (phase_end) state_in = lavm_pkg::B_DOT;
         lavm_pkg::B_DOT:     if (phase_end) state_in = lavm_pkg::B_EMIT;
         lavm_pkg::B_EMIT:    if (row_ff == 2'd3) state_in = lavm_pkg::B_IDLE;
         default:             state_in = lavm_pkg::B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      item_pop   = (state_ff == lavm_pkg::B_IDLE) && item_valid;
      norm_start = item_pop || ((state_ff == lavm_pkg::B_CROSS_C) && phase_end);
      for (int i = 0; i < 3; i++) begin
         norm_vec[i] = (state_ff == lavm_pkg::B_IDLE) ?
                       64'(signed'(item.diff[i])) : c_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lavm_pkg::B_IDLE;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= (state_ff == lavm_pkg::B_EMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         for (int i = 0; i < 3; i++) begin
            eye_ff[i] <= signed'(item.eye[i]);
            up_ff[i]  <= signed'(item.up[i]);
         end
         sat_ff <= 1'b0;
      end
      if (state_ff == lavm_pkg::B_NORM_Z && norm_stat.done) begin
         z_ff     <= norm_unit;
         degen_ff <= norm_stat.degen;
      end
      if (state_ff == lavm_pkg::B_NORM_X && norm_stat.done) begin
         x_ff     <= norm_unit;
         degen_ff <= degen_ff | norm_stat.degen;
      end

      // hold the step count at zero outside the product phases
      k_ff    <= (phase_end || !(state_ff == lavm_pkg::B_CROSS_C ||
                                 state_ff == lavm_pkg::B_CROSS_Y ||
                                 state_ff == lavm_pkg::B_DOT)) ? 4'd0 : k_ff + 4'd1;
      prod_ff <= PROD_W'(mul_a * mul_b);

      // accumulate stage trails the multiplier, working on its registered product and tag
      if (tag_ff.valid) begin
         acc_ff <= sum;
         if (tag_ff.last) begin
            case (state_ff)
               lavm_pkg::B_CROSS_C: c_ff[tag_ff.dst] <= sum;
               lavm_pkg::B_CROSS_Y: y_ff[tag_ff.dst] <= COMP_W'(rnd);
               lavm_pkg::B_DOT: begin
                  if (rnd > 64'sd2147483647) begin
                     dot_ff[tag_ff.dst] <= 32'sh7fffffff;
                     sat_ff <= 1'b1;
                  end else if (rnd < -64'sd2147483648) begin
                     dot_ff[tag_ff.dst] <= 32'sh80000000;
                     sat_ff <= 1'b1;
                  end else begin
                     dot_ff[tag_ff.dst] <= 32'(rnd);
                  end
               end
               default: begin
               end
            endcase
         end
      end

      row_ff <= (state_ff == lavm_pkg::B_EMIT) ? row_ff + 2'd1 : 2'd0;

      rsp_row_ff   <= row_ff;
      rsp_last_ff  <= (row_ff == 2'd3);
      rsp_degen_ff <= degen_ff;
      rsp_sat_ff   <= (row_ff == 2'd3) && sat_ff;
      if (row_ff == 2'd3) begin
         rsp_a_ff <= dot_ff[0];
         rsp_b_ff <= dot_ff[1];
         rsp_c_ff <= dot_ff[2];
         rsp_d_ff <= 32'sd1 <<< FRAC_BITS;
      end else begin
         rsp_a_ff <= 32'(x_ff[row_ff]);
         rsp_b_ff <= 32'(y_ff[row_ff]);
         rsp_c_ff <= 32'(z_ff[row_ff]);
         rsp_d_ff <= '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_index  = rsp_row_ff;
   assign rsp_elem_a     = rsp_a_ff;
   assign rsp_elem_b     = rsp_b_ff;
   assign rsp_elem_c     = rsp_c_ff;
   assign rsp_elem_d     = rsp_d_ff;
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign rsp_last_row   = rsp_last_ff;

   `LAVM_ASSERT_NEXT(back_rows_run, clock, reset, rsp_valid_ff && !rsp_last_ff, rsp_valid_ff)
   `LAVM_ASSERT_NEXT(back_rows_end, clock, reset, rsp_valid_ff && rsp_last_ff, !rsp_valid_ff)
   `LAVM_ASSERT(back_last_is_row3, clock, reset, rsp_valid_ff, rsp_last_ff == (rsp_row_ff == 2'd3))

endmodule

// ===== tb/sv/lavm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_checker
// Watches the request and row channels of the look-at view matrix block,
// predicts the four matrix rows of every accepted request and compares them.
// ----------------------------------------------------------------------------
module lavm_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_up_x,
   input  logic signed [31:0] req_up_y,
   input  logic signed [31:0] req_up_z,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_row_index,
   input  logic signed [31:0] rsp_elem_a,
   input  logic signed [31:0] rsp_elem_b,
   input  logic signed [31:0] rsp_elem_c,
   input  logic signed [31:0] rsp_elem_d,
   input  logic               rsp_degenerate,
   input  logic               rsp_saturated,
   input  logic               rsp_last_row,
   output int                 fail_count,
   output int                 rows_pending
);

   localparam int FB = lavm_pkg::FRAC_BITS_DEF;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] elem_a;
      logic signed [31:0] elem_b;
      logic signed [31:0] elem_c;
      logic signed [31:0] elem_d;
      logic               degenerate;
      logic               saturated;
      logic               last_row;
   } matrix_row_type;

   matrix_row_type expected_rows[$];

   function automatic longint unsigned mag(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned max_mag(input longint a, input longint b,
                                               input longint c);
      longint unsigned m;
      m = mag(a);
      if (mag(b) > m) m = mag(b);
      if (mag(c) > m) m = mag(c);
      return m;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Align the largest magnitude into [2^30, 2^31), then divide by the
   // floored integer length with round to nearest. Returns 1 on a zero vector.
   function automatic bit unit_vec(input longint a0, input longint a1, input longint a2,
                                   output longint o0, output longint o1,
                                   output longint o2);
      longint unsigned m, s, len;
      m = max_mag(a0, a1, a2);
      o0 = 0; o1 = 0; o2 = 0;
      if (m == 0) return 1'b1;
      while (m >= (64'd1 << 31)) begin
         a0 = a0 / 2; a1 = a1 / 2; a2 = a2 / 2;
         m = max_mag(a0, a1, a2);
      end
      while (m < (64'd1 << 30)) begin
         a0 = a0 * 2; a1 = a1 * 2; a2 = a2 * 2;
         m = max_mag(a0, a1, a2);
      end
      s = mag(a0) * mag(a0) + mag(a1) * mag(a1) + mag(a2) * mag(a2);
      len = int_sqrt(s);
      o0 = longint'(((mag(a0) << FB) + (len >> 1)) / len);
      o1 = longint'(((mag(a1) << FB) + (len >> 1)) / len);
      o2 = longint'(((mag(a2) << FB) + (len >> 1)) / len);
      if (a0 < 0) o0 = -o0;
      if (a1 < 0) o1 = -o1;
      if (a2 < 0) o2 = -o2;
      return 1'b0;
   endfunction

   function automatic longint round_q(input longint v);
      return (v + (longint'(1) <<< (FB - 1))) >>> FB;
   endfunction

   function automatic logic signed [31:0] clamp_q(input longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   task automatic predict_view_rows();
      longint ex, ey, ez, zx, zy, zz, xx, xy, xz, yx, yy, yz, cx, cy, cz;
      logic signed [31:0] d0, d1, d2;
      bit degen, sat;
      matrix_row_type r;
      ex = req_eye_x; ey = req_eye_y; ez = req_eye_z;
      degen = unit_vec(ex - longint'(req_target_x), ey - longint'(req_target_y),
                       ez - longint'(req_target_z), zx, zy, zz);
      cx = longint'(req_up_y) * zz - longint'(req_up_z) * zy;
      cy = longint'(req_up_z) * zx - longint'(req_up_x) * zz;
      cz = longint'(req_up_x) * zy - longint'(req_up_y) * zx;
      if (unit_vec(cx, cy, cz, xx, xy, xz)) degen = 1'b1;
      yx = round_q(zy * xz - zz * xy);
      yy = round_q(zz * xx - zx * xz);
      yz = round_q(zx * xy - zy * xx);
      sat = 1'b0;
      d0 = clamp_q(round_q(-(xx * ex + xy * ey + xz * ez)), sat);
      d1 = clamp_q(round_q(-(yx * ex + yy * ey + yz * ez)), sat);
      d2 = clamp_q(round_q(-(zx * ex + zy * ey + zz * ez)), sat);
      r = '0;
      r.degenerate = degen;
      r.row_index = 2'd0; r.elem_a = 32'(xx); r.elem_b = 32'(yx); r.elem_c = 32'(zx);
      expected_rows.push_back(r);
      r.row_index = 2'd1; r.elem_a = 32'(xy); r.elem_b = 32'(yy); r.elem_c = 32'(zy);
      expected_rows.push_back(r);
      r.row_index = 2'd2; r.elem_a = 32'(xz); r.elem_b = 32'(yz); r.elem_c = 32'(zz);
      expected_rows.push_back(r);
      r.row_index = 2'd3; r.elem_a = d0; r.elem_b = d1; r.elem_c = d2;
      r.elem_d = 32'sd1 <<< FB; r.saturated = sat; r.last_row = 1'b1;
      expected_rows.push_back(r);
   endtask

   always @(posedge clock) begin
      matrix_row_type got, want;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (start && !busy) predict_view_rows();
         if (rsp_valid) begin
            got = '{rsp_row_index, rsp_elem_a, rsp_elem_b, rsp_elem_c, rsp_elem_d,
                    rsp_degenerate, rsp_saturated, rsp_last_row};
            if (expected_rows.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected row transfer: %p", got);
            end else begin
               want = expected_rows.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) $display("row mismatch: exp %p got %p", want, got);
               end
            end
         end
      end
      rows_pending = expected_rows.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives look-at requests into the view matrix block with random gaps and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
   logic signed [31:0] tgt_x = '0, tgt_y = '0, tgt_z = '0;
   logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
   logic               rsp_valid, rsp_degenerate, rsp_saturated, rsp_last_row;
   logic [1:0]         rsp_row_index;
   logic signed [31:0] rsp_elem_a, rsp_elem_b, rsp_elem_c, rsp_elem_d;
   int                 fail_count, rows_pending;
   int                 idle_cycles = 0;

   localparam int WATCHDOG = 5000;
   localparam int TAIL     = 400;   // longer than one back-end pass

   always #4 clock = ~clock;

   look_at_view_matrix i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_eye_x(eye_x), .req_eye_y(eye_y), .req_eye_z(eye_z),
      .req_target_x(tgt_x), .req_target_y(tgt_y), .req_target_z(tgt_z),
      .req_up_x(up_x), .req_up_y(up_y), .req_up_z(up_z),
      .rsp_valid(rsp_valid), .rsp_row_index(rsp_row_index),
      .rsp_elem_a(rsp_elem_a), .rsp_elem_b(rsp_elem_b),
      .rsp_elem_c(rsp_elem_c), .rsp_elem_d(rsp_elem_d),
      .rsp_degenerate(rsp_degenerate), .rsp_saturated(rsp_saturated),
      .rsp_last_row(rsp_last_row)
   );

   lavm_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_eye_x(eye_x), .req_eye_y(eye_y), .req_eye_z(eye_z),
      .req_target_x(tgt_x), .req_target_y(tgt_y), .req_target_z(tgt_z),
      .req_up_x(up_x), .req_up_y(up_y), .req_up_z(up_z),
      .rsp_valid(rsp_valid), .rsp_row_index(rsp_row_index),
      .rsp_elem_a(rsp_elem_a), .rsp_elem_b(rsp_elem_b),
      .rsp_elem_c(rsp_elem_c), .rsp_elem_d(rsp_elem_d),
      .rsp_degenerate(rsp_degenerate), .rsp_saturated(rsp_saturated),
      .rsp_last_row(rsp_last_row),
      .fail_count(fail_count), .rows_pending(rows_pending)
   );

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Mostly short gaps, now and then a long one, often none at all.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // Small coordinates keep the geometry ordinary; full-width ones cover every bit.
   function automatic logic signed [31:0] rand_coord(input bit full);
      if (full) return $urandom;
      return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
   endfunction

   // Present one request, hold it until the transfer, then maybe idle.
   task automatic send_view(input logic signed [31:0] ex, ey, ez, tx, ty, tz,
                            ux, uy, uz);
      int gap;
      eye_x <= ex; eye_y <= ey; eye_z <= ez;
      tgt_x <= tx; tgt_y <= ty; tgt_z <= tz;
      up_x  <= ux; up_y  <= uy; up_z  <= uz;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   localparam logic signed [31:0] ONE  = 32'sh00010000;
   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;

   initial begin
      logic signed [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
      int sel, k;
      bit full;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: plain camera, eye on target, up zero, up along the view axis,
      // extreme coordinates and saturating translations.
      send_view(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
      send_view(3 * ONE, -2 * ONE, ONE, 3 * ONE, -2 * ONE, ONE, 0, ONE, 0);
      send_view(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0);
      send_view(0, 0, 4 * ONE, 0, 0, 0, 0, 0, 7 * ONE);
      send_view(0, 0, 4 * ONE, 0, 0, ONE, 0, 0, -ONE);
      send_view(MAXV, MAXV, MAXV, 0, 0, 0, 0, ONE, 0);
      send_view(MINV, MINV, MINV, 0, 0, 0, 0, ONE, 0);
      send_view(MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MINV, MAXV);
      send_view(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, MINV);
      send_view(MAXV, 0, 0, MINV, 0, 0, 0, MAXV, 0);
      send_view(MINV, 0, 0, 0, 0, 0, 0, 0, MINV);
      send_view(0, 0, 1, 0, 0, 0, 1, 0, 0);
      send_view(1, 1, 1, 0, 0, 0, -1, 1, 0);
      send_view(-1, -1, -1, -1, -1, -1, 1, 1, 1);
      send_view(32'sh00008000, 0, MINV, 0, MAXV, 0, MAXV, MAXV, MAXV);
      send_view(0, 0, 0, 0, 0, 0, 0, 0, 0);

      // Random: ordinary cameras, full-width noise and a few degenerate shapes.
      for (k = 0; k < 300; k++) begin
         sel = $urandom_range(0, 99);
         full = (sel >= 60);
         ex = rand_coord(full); ey = rand_coord(full); ez = rand_coord(full);
         tx = rand_coord(full); ty = rand_coord(full); tz = rand_coord(full);
         ux = rand_coord(full); uy = rand_coord(full); uz = rand_coord(full);
         if (sel < 5) begin
            tx = ex; ty = ey; tz = ez;
         end else if (sel < 10) begin
            ux = ex - tx; uy = ey - ty; uz = ez - tz;
         end else if (sel < 13) begin
            ux = 0; uy = 0; uz = 0;
         end
         send_view(ex, ey, ez, tx, ty, tz, ux, uy, uz);
      end
      start <= 1'b0;

      // Drain, then wait longer than one back-end pass for stray rows.
      while (rows_pending != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lavm_pkg.sv
hdl/lavm_front.sv
hdl/lavm_norm.sv
hdl/lavm_back.sv
hdl/look_at_view_matrix.sv
tb/sv/lavm_checker.sv
tb/sv/tb.sv
